// ===== sv/swq_pkg.sv =====
// ----------------------------------------------------------------------------
// swq_pkg - shared types and codes for the sorted wakeup queue
// status codes, field widths and the insert command sent along the cell row
// ----------------------------------------------------------------------------
`default_nettype none

package swq_pkg;

  localparam int STATUS_W = 3;
  localparam int ENTRY_W  = 5;
  localparam int POS_W    = 5;
  localparam int LEN_W    = 6;
  localparam int HEAD_T_W = 16;
  localparam int MASK_W   = 32;

  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_ENABLED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_NUMBER  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNUSED      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SLEEPING    = 3'd4;

  localparam logic REG_ENABLED = 1'b0;
  localparam logic REG_IN_USE  = 1'b1;

  // insert command broadcast to every cell
  typedef struct packed {
    logic               en;
    logic [ENTRY_W-1:0] entry;
  } swq_ins_t;

endpackage

`default_nettype wire

// ===== sv/sorted_wakeup_queue_insert.sv =====
// ----------------------------------------------------------------------------
// sorted_wakeup_queue_insert - sleep request checker and sorted queue insert
// a request goes through the check state, the insert state when inserted, and the
//   report state, which loads the result; one request in the sequencer at a time,
//   so the next is taken only after that result is loaded, past any output stall
// the queue is a row of cells that all compare and shift together in the insert state
// rst (synchronous) clears config, sleeping marks, cell valid bits and count
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_wakeup_queue_insert
  import swq_pkg::*;
#(
  parameter int ENTRIES     = 32,
  parameter int BASE_NUMBER = 32,
  parameter int TIME_BITS   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration writes
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  // request stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,  // entry_number[7:0], delay_ticks[23:8], now_ticks[39:24]
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata   // status[2:0], insert_position[7:3], head_entry[12:8],
                                     // head_wake_time[28:13], queue_length[34:29], zero pad
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  // sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CHECK  = 2'd1;
  localparam logic [1:0] S_INSERT = 2'd2;
  localparam logic [1:0] S_REPORT = 2'd3;

  logic [1:0]           state;

  // configuration registers
  logic                 enabled;
  logic [MASK_W-1:0]    in_use_mask;

  // captured request
  logic [7:0]           req_num;
  logic [15:0]          req_delay;
  logic [15:0]          req_now;

  // check results
  logic [STATUS_W-1:0]  status;
  logic [IDX_W-1:0]     idx;
  logic [TIME_BITS-1:0] wake_time;
  logic [POS_W-1:0]     position;

  logic [ENTRIES-1:0]   sleeping;
  logic [CNT_W-1:0]     count;

  // output register
  logic [39:0]          out_data;
  logic                 out_valid;

  // ---- request checks, evaluated in the check state ----
  logic [8:0]           diff;
  logic                 below_base;
  logic                 out_of_range;
  logic                 unused;
  logic [STATUS_W-1:0]  chk_status;

  assign diff         = {1'b0, req_num} - 9'(BASE_NUMBER);
  assign below_base   = {1'b0, req_num} < 9'(BASE_NUMBER);
  assign out_of_range = below_base || (diff >= 9'(ENTRIES));
  // entries past the mask width have no in-use bit
  assign unused       = (diff >= 9'(MASK_W)) || !in_use_mask[diff[4:0]];

  always_comb begin
    if (!enabled) begin
      chk_status = ST_NOT_ENABLED;
    end else if (out_of_range) begin
      chk_status = ST_BAD_NUMBER;
    end else if (unused) begin
      chk_status = ST_UNUSED;
    end else if (sleeping[diff[IDX_W-1:0]]) begin
      chk_status = ST_SLEEPING;
    end else begin
      chk_status = ST_OK;
    end
  end

  // ---- cell row ----
  swq_ins_t             ins;
  logic [ENTRIES-1:0]   cell_later;
  logic [ENTRIES-1:0]   cell_valid;
  logic [ENTRY_W-1:0]   cell_entry [ENTRIES];
  logic [TIME_BITS-1:0] cell_wake  [ENTRIES];
  logic [ENTRIES-1:0]   take;
  logic [POS_W-1:0]     take_pos;

  assign ins.en    = (state == S_INSERT);
  assign ins.entry = ENTRY_W'(idx);

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      swq_cell #(.TIME_BITS(TIME_BITS)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ins        (ins),
        .ins_wake   (wake_time),
        .left_later (1'b0),
        .left_valid (1'b0),
        .left_entry ('0),
        .left_wake  ('0),
        .later      (cell_later[i]),
        .valid      (cell_valid[i]),
        .entry      (cell_entry[i]),
        .wake       (cell_wake[i])
      );
      assign take[i] = cell_later[i];
    end else begin : g_body
      swq_cell #(.TIME_BITS(TIME_BITS)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ins        (ins),
        .ins_wake   (wake_time),
        .left_later (cell_later[i-1]),
        .left_valid (cell_valid[i-1]),
        .left_entry (cell_entry[i-1]),
        .left_wake  (cell_wake[i-1]),
        .later      (cell_later[i]),
        .valid      (cell_valid[i]),
        .entry      (cell_entry[i]),
        .wake       (cell_wake[i])
      );
      // row is sorted with valid cells first, so the later flags form a
      // suffix and exactly one cell sees the boundary
      assign take[i] = cell_later[i] && !cell_later[i-1];
    end
  end

  // one-hot slot to position
  always_comb begin
    take_pos = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (take[i]) begin
        take_pos = take_pos | POS_W'(i);
      end
    end
  end

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      enabled     <= 1'b0;
      in_use_mask <= '0;
      sleeping    <= '0;
      count       <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ENABLED: enabled     <= cfg_data[0];
          REG_IN_USE:  in_use_mask <= cfg_data;
          default:     ;
        endcase
      end

      // the report state reloads the output register itself
      if (out_valid && m_tready && state != S_REPORT) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (chk_status == ST_OK) begin
            sleeping[diff[IDX_W-1:0]] <= 1'b1;
          end
          // full queue cannot occur, but the insert is dropped if it does
          if (chk_status == ST_OK && count != CNT_W'(ENTRIES)) begin
            state <= S_INSERT;
          end else begin
            state <= S_REPORT;
          end
        end
        S_INSERT: begin
          count <= count + 1'b1;
          state <= S_REPORT;
        end
        S_REPORT: begin
          if (!out_valid || m_tready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid) begin
      req_num   <= s_tdata[7:0];
      req_delay <= s_tdata[23:8];
      req_now   <= s_tdata[39:24];
    end
    if (state == S_CHECK) begin
      status    <= chk_status;
      idx       <= diff[IDX_W-1:0];
      wake_time <= TIME_BITS'(req_delay) + TIME_BITS'(req_now);
      position  <= '0;
    end
    if (state == S_INSERT) begin
      position <= take_pos;
    end
    if (state == S_REPORT && (!out_valid || m_tready)) begin
      out_data <= {5'd0,
                   LEN_W'(count),
                   cell_valid[0] ? HEAD_T_W'(cell_wake[0]) : HEAD_T_W'(0),
                   cell_valid[0] ? cell_entry[0] : ENTRY_W'(0),
                   position,
                   status};
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

`default_nettype wire

// ===== sv/swq_cell.sv =====
// ----------------------------------------------------------------------------
// swq_cell - one slot of the sorted wakeup queue
// holds an entry and its wake time; on insert it keeps, shifts in its left
// neighbor, or takes the new entry
// ----------------------------------------------------------------------------
`default_nettype none

module swq_cell
  import swq_pkg::*;
#(
  parameter int TIME_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire swq_ins_t             ins,
  input  wire logic [TIME_BITS-1:0] ins_wake,
  input  wire logic                 left_later,
  input  wire logic                 left_valid,
  input  wire logic [ENTRY_W-1:0]   left_entry,
  input  wire logic [TIME_BITS-1:0] left_wake,
  output logic                      later,
  output logic                      valid,
  output logic [ENTRY_W-1:0]        entry,
  output logic [TIME_BITS-1:0]      wake
);

  // new item goes before this slot: slot empty or strictly later
  assign later = !valid || (wake > ins_wake);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ins.en && later) begin
      if (left_later) begin
        valid <= left_valid;
        entry <= left_entry;
        wake  <= left_wake;
      end else begin
        valid <= 1'b1;
        entry <= ins.entry;
        wake  <= ins_wake;
      end
    end
  end

endmodule

`default_nettype wire
